// ----- design/servo_command_packet_framer_assert.svh -----
// Assertion macros for the servo command packet framer checker.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef SERVO_COMMAND_PACKET_FRAMER_ASSERT_SVH
`define SERVO_COMMAND_PACKET_FRAMER_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define SCPF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("scpf: check failed");

// Next-cycle implication, checked outside reset
`define SCPF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("scpf: check failed");

`endif

// ----- design/scpf_pkg.sv -----
// Shared types, constants and the CRC step for the servo command packet framer.
// No dependencies; imported by front end, queue, back end, top and testbench.
package scpf_pkg;

  // Command kinds
  typedef enum logic [1:0] {
    OP_VELOCITY = 2'd0,
    OP_POSITION = 2'd1,
    OP_TORQUE   = 2'd2,
    OP_UNUSED   = 2'd3
  } op_e;

  // Packet constants
  localparam logic [7:0]  HdrByte0    = 8'hFF;
  localparam logic [7:0]  HdrByte2    = 8'hFD;
  localparam logic [7:0]  ReservedByte = 8'h00;
  localparam logic [7:0]  InstrBase   = 8'h10;
  localparam logic [7:0]  LenBase     = 8'd4;
  localparam logic [15:0] CrcPoly     = 16'h8005;
  localparam logic [15:0] CrcInit     = 16'h0000;

  // Byte positions within a packet
  localparam logic [3:0] PosHdr0  = 4'd0;
  localparam logic [3:0] PosHdr1  = 4'd1;
  localparam logic [3:0] PosHdr2  = 4'd2;
  localparam logic [3:0] PosLen   = 4'd3;
  localparam logic [3:0] PosRsv   = 4'd4;
  localparam logic [3:0] PosId    = 4'd5;
  localparam logic [3:0] PosInstr = 4'd6;
  localparam logic [3:0] PosGoalH = 4'd7;
  localparam logic [3:0] PosGoalL = 4'd8;
  localparam logic [3:0] PosDir   = 4'd9;

  // Bytes covered by the CRC, with and without the direction byte
  localparam logic [3:0] DataBytesDir   = 4'd10;
  localparam logic [3:0] DataBytesNoDir = 4'd9;

  // Default depth of the command queue
  localparam int unsigned QueueDepthDef = 2;

  // One classified command, ready to be serialised
  typedef struct packed {
    logic [7:0]  motor_id;
    logic [7:0]  instr;
    logic [7:0]  len;
    logic [15:0] goal;
    logic [7:0]  direction;
    logic        has_dir;
  } desc_t;

  // Queue head as seen by the serialiser
  typedef struct packed {
    logic  valid;
    desc_t desc;
  } head_t;

  // Fold one byte into the CRC-16, MSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] c;
    c = acc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- design/scpf_cmd_if.sv -----
// Command channel: valid/ready handshake carrying one servo command.
// Depends on nothing.
interface scpf_cmd_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic [7:0]         motor_id;
  logic signed [15:0] goal_value;
  logic [7:0]         direction;

  modport source (output valid, output op, output motor_id, output goal_value,
                  output direction, input ready);
  modport sink   (input valid, input op, input motor_id, input goal_value,
                  input direction, output ready);
endinterface

// ----- design/scpf_byte_if.sv -----
// Byte channel: valid/ready handshake carrying one packet byte and its end flag.
// Depends on nothing.
interface scpf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       last;

  modport source (output valid, output tx_byte, output last, input ready);
  modport sink   (input valid, input tx_byte, input last, output ready);
endinterface

// ----- design/scpf_front.sv -----
// Front end: takes commands, drops unused op codes, builds packet descriptors.
// Depends on scpf_pkg.
module scpf_front (
  input  logic               cmd_valid_i,
  input  logic [1:0]         cmd_op_i,
  input  logic [7:0]         cmd_motor_id_i,
  input  logic signed [15:0] cmd_goal_value_i,
  input  logic [7:0]         cmd_direction_i,
  output logic               cmd_ready_o,
  input  logic               q_full_i,
  output logic               push_o,
  output scpf_pkg::desc_t    desc_o
);
  import scpf_pkg::*;

  op_e op;

  assign op = op_e'(cmd_op_i);

  // Accept whenever the queue has room; unused codes are taken and dropped
  assign cmd_ready_o = !q_full_i;
  assign push_o      = cmd_valid_i && !q_full_i && (op != OP_UNUSED);

  // Classify: position carries no direction byte
  always_comb begin
    desc_o.motor_id  = cmd_motor_id_i;
    desc_o.instr     = InstrBase + {6'b0, cmd_op_i};
    desc_o.has_dir   = (op != OP_POSITION);
    desc_o.len       = LenBase + (desc_o.has_dir ? 8'd3 : 8'd2);
    desc_o.goal      = cmd_goal_value_i;
    desc_o.direction = cmd_direction_i;
  end

endmodule

// ----- design/scpf_queue.sv -----
// Short descriptor queue between the front end and the serialiser.
// Depends on scpf_pkg.
module scpf_queue #(
  parameter int unsigned Depth = scpf_pkg::QueueDepthDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  scpf_pkg::desc_t desc_i,
  output logic            full_o,
  input  logic            pop_i,
  output scpf_pkg::head_t head_o
);
  import scpf_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  desc_t           entries_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o      = (count_q == CntW'(Depth));
  assign head_o.valid = (count_q != '0);
  assign head_o.desc  = entries_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && head_o.valid;

  // Advance pointers with wrap, track fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the descriptor
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= desc_i;
    end
  end

endmodule

// ----- design/scpf_back.sv -----
// Back end: serialises the head one byte per unstalled cycle, with a running CRC.
// Depends on scpf_pkg.
module scpf_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  scpf_pkg::head_t head_i,
  output logic            pop_o,
  output logic            tx_valid_o,
  input  logic            tx_ready_i,
  output logic [7:0]      tx_byte_o,
  output logic            tx_last_o
);
  import scpf_pkg::*;

  logic [3:0]  idx_q, idx_d;
  logic [15:0] crc_q, crc_d;
  logic        valid_q, valid_d;
  logic [7:0]  byte_q, byte_d;
  logic        last_q, last_d;
  logic [3:0]  n_data;
  logic        is_data, is_last, advance;
  logic [7:0]  cur_byte, data_byte;

  assign n_data  = head_i.desc.has_dir ? DataBytesDir : DataBytesNoDir;
  assign is_data = (idx_q < n_data);
  assign is_last = (idx_q == n_data + 4'd1);
  assign advance = head_i.valid && (!valid_q || tx_ready_i);
  assign pop_o   = advance && is_last;

  // Select the data byte at the current position
  always_comb begin
    unique case (idx_q)
      PosHdr0, PosHdr1: data_byte = HdrByte0;
      PosHdr2:          data_byte = HdrByte2;
      PosLen:           data_byte = head_i.desc.len;
      PosRsv:           data_byte = ReservedByte;
      PosId:            data_byte = head_i.desc.motor_id;
      PosInstr:         data_byte = head_i.desc.instr;
      PosGoalH:         data_byte = head_i.desc.goal[15:8];
      PosGoalL:         data_byte = head_i.desc.goal[7:0];
      default:          data_byte = head_i.desc.direction;
    endcase
  end

  // Data bytes first, then the CRC high and low bytes
  always_comb begin
    priority if (is_data) begin
      cur_byte = data_byte;
    end else if (!is_last) begin
      cur_byte = crc_q[15:8];
    end else begin
      cur_byte = crc_q[7:0];
    end
  end

  // Advance position and CRC; refill the output register
  always_comb begin
    idx_d   = idx_q;
    crc_d   = crc_q;
    byte_d  = byte_q;
    last_d  = last_q;
    valid_d = valid_q && !tx_ready_i;
    if (advance) begin
      valid_d = 1'b1;
      byte_d  = cur_byte;
      last_d  = is_last;
      if (is_last) begin
        idx_d = '0;
        crc_d = CrcInit;
      end else begin
        idx_d = idx_q + 4'd1;
        crc_d = is_data ? crc_byte(crc_q, cur_byte) : crc_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      crc_q   <= CrcInit;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      crc_q   <= crc_d;
      valid_q <= valid_d;
    end
  end

  // Output payload holds while stalled
  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    last_q <= last_d;
  end

  assign tx_valid_o = valid_q;
  assign tx_byte_o  = byte_q;
  assign tx_last_o  = last_q;

endmodule

// ----- design/servo_command_packet_framer.sv -----
// Channel   Dir  Payload                                   Notes
// cmd_i     in   op, motor_id, goal_value, direction       op 3 is taken and dropped
// tx_o      out  tx_byte, last                             last on CRC low byte
//
// A packet is 12 bytes (velocity, torque) or 11 bytes (position), one byte per
// cycle through the output register while tx_o.ready is high. A command
// reaches the queue in the cycle it is accepted; its first byte then passes
// through the queue head and the output register before it is offered. The queue
// (QueueDepth entries) takes new commands while a packet streams. Reset clears
// queue, byte counter, CRC and tx valid. tx_o.ready low holds the output byte and
// stalls the serialiser; cmd_i.ready drops once the queue is full.
module servo_command_packet_framer #(
  parameter int unsigned QueueDepth = scpf_pkg::QueueDepthDef
) (
  input logic         clk_i,
  input logic         rst_ni,
  scpf_cmd_if.sink    cmd_i,
  scpf_byte_if.source tx_o
);
  import scpf_pkg::*;

  logic  q_full, push, pop;
  desc_t desc;
  head_t head;

  scpf_front u_front (
    .cmd_valid_i      (cmd_i.valid),
    .cmd_op_i         (cmd_i.op),
    .cmd_motor_id_i   (cmd_i.motor_id),
    .cmd_goal_value_i (cmd_i.goal_value),
    .cmd_direction_i  (cmd_i.direction),
    .cmd_ready_o      (cmd_i.ready),
    .q_full_i         (q_full),
    .push_o           (push),
    .desc_o           (desc)
  );

  scpf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .desc_i (desc),
    .full_o (q_full),
    .pop_i  (pop),
    .head_o (head)
  );

  scpf_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .pop_o      (pop),
    .tx_valid_o (tx_o.valid),
    .tx_ready_i (tx_o.ready),
    .tx_byte_o  (tx_o.tx_byte),
    .tx_last_o  (tx_o.last)
  );

endmodule

// ----- design/scpf_checker.sv -----
// Port-level checks on the packet stream of the servo command packet framer.
// Depends on servo_command_packet_framer_assert.svh; bound to the top level.
`include "servo_command_packet_framer_assert.svh"

module scpf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       tx_valid_i,
  input logic       tx_ready_i,
  input logic [7:0] tx_byte_i,
  input logic       tx_last_i
);

  logic       xfer;
  logic [3:0] pos_q;

  assign xfer = tx_valid_i && tx_ready_i;

  // Track byte position within the current packet
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (xfer) begin
      pos_q <= tx_last_i ? 4'd0 : pos_q + 4'd1;
    end
  end

  `SCPF_ASSERT_NEXT(a_stall_hold, tx_valid_i && !tx_ready_i, tx_valid_i && $stable(tx_byte_i) && $stable(tx_last_i))
  `SCPF_ASSERT_NOW(a_first_byte, xfer && (pos_q == 4'd0), (tx_byte_i == 8'hFF) && !tx_last_i)
  `SCPF_ASSERT_NOW(a_hdr_fd, xfer && (pos_q == 4'd2), tx_byte_i == 8'hFD)
  `SCPF_ASSERT_NOW(a_last_pos, xfer && tx_last_i, (pos_q == 4'd10) || (pos_q == 4'd11))

endmodule

bind servo_command_packet_framer scpf_checker u_scpf_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .tx_valid_i (tx_o.valid),
  .tx_ready_i (tx_o.ready),
  .tx_byte_i  (tx_o.tx_byte),
  .tx_last_i  (tx_o.last)
);

// ----- sim/servo_command_packet_framer_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for servo_command_packet_framer: random commands in, packet bytes out.
// Depends on scpf_pkg, scpf_cmd_if, scpf_byte_if and the framer RTL.
module servo_command_packet_framer_test;
  import scpf_pkg::*;

  localparam int unsigned IdleLimit     = 2000;
  localparam int unsigned TailCycles    = 30;
  localparam int unsigned RandomCmds    = 200;
  localparam int unsigned HoldAtPacket  = 120;
  localparam int unsigned HoldCycles    = 150;
  localparam int unsigned BurstFrom     = 40;
  localparam int unsigned BurstTo       = 70;

  // One command to send, with the idle cycles that precede it
  typedef struct {
    op_e                op;
    logic [7:0]         motor_id;
    logic signed [15:0] goal;
    logic [7:0]         direction;
    int unsigned        gap;
    bit                 wait_idle;
  } servo_cmd_t;

  // One expected packet byte
  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last;
  } pkt_byte_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  scpf_cmd_if  cmd_ch ();
  scpf_byte_if tx_ch ();

  servo_command_packet_framer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_ch),
    .tx_o   (tx_ch)
  );

  servo_cmd_t  pending_cmds[$];
  pkt_byte_t   packet_bytes[$];
  int unsigned n_cmds        = 0;
  int unsigned cmds_accepted = 0;
  int unsigned error_count   = 0;
  int unsigned packets_seen  = 0;
  int unsigned bytes_seen    = 0;
  int unsigned gap_count     = 0;
  int unsigned stall_left    = 0;
  int unsigned hold_left     = 0;
  int unsigned idle_cycles   = 0;

  always #10 clk_i = ~clk_i;

  // Advance the CRC-16 by one byte, one message bit at a time
  function automatic logic [15:0] crc16_fold(input logic [15:0] acc, input logic [7:0] data);
    logic [15:0] r;
    logic        fb;
    r = acc;
    for (int b = 7; b >= 0; b--) begin
      fb = r[15] ^ data[b];
      r  = {r[14:0], 1'b0} ^ (fb ? CrcPoly : 16'h0000);
    end
    return r;
  endfunction

  // Append one expected byte to the tail of the expected stream
  function automatic void expect_byte(input logic [7:0] b, input logic l);
    pkt_byte_t pb;
    pb.tx_byte = b;
    pb.last    = l;
    packet_bytes.insert(packet_bytes.size(), pb);
  endfunction

  // Build the packet for one command and queue its bytes
  function automatic void frame_command(input op_e op, input logic [7:0] id,
                                        input logic [15:0] goal, input logic [7:0] dir);
    logic [7:0]  body[12];
    int          n;
    logic [15:0] crc;
    if (op != OP_UNUSED) begin
      body[0] = HdrByte0;
      body[1] = HdrByte0;
      body[2] = HdrByte2;
      body[3] = (op == OP_POSITION) ? LenBase + 8'd2 : LenBase + 8'd3;
      body[4] = ReservedByte;
      body[5] = id;
      body[6] = InstrBase + 8'(op);
      body[7] = goal[15:8];
      body[8] = goal[7:0];
      n = 9;
      if (op != OP_POSITION) begin
        body[9] = dir;
        n = 10;
      end
      crc = CrcInit;
      for (int i = 0; i < n; i++) begin
        crc = crc16_fold(crc, body[i]);
        expect_byte(body[i], 1'b0);
      end
      expect_byte(crc[15:8], 1'b0);
      expect_byte(crc[7:0], 1'b1);
    end
  endfunction

  task automatic add_cmd(input op_e op, input logic [7:0] id, input logic [15:0] goal,
                         input logic [7:0] dir, input int unsigned gap, input bit wait_idle);
    servo_cmd_t c;
    c.op        = op;
    c.motor_id  = id;
    c.goal      = goal;
    c.direction = dir;
    c.gap       = gap;
    c.wait_idle = wait_idle;
    pending_cmds.insert(pending_cmds.size(), c);
    n_cmds++;
  endtask

  task automatic flag_mismatch(input string what, input logic [7:0] want, input logic [7:0] got);
    error_count++;
    $display("%0t: byte %0d %s mismatch: expected %02h, actual %02h",
             $time, bytes_seen, what, want, got);
  endtask

  // Command driver: offer the next pending command once its gap has passed
  always @(posedge clk_i or negedge rst_ni) begin : drive_commands
    logic offer;
    if (!rst_ni) begin
      cmd_ch.valid      <= 1'b0;
      cmd_ch.op         <= 2'd0;
      cmd_ch.motor_id   <= 8'd0;
      cmd_ch.goal_value <= 16'sd0;
      cmd_ch.direction  <= 8'd0;
      gap_count = 0;
    end else begin
      offer = cmd_ch.valid;
      if (cmd_ch.valid && cmd_ch.ready) begin
        frame_command(op_e'(cmd_ch.op), cmd_ch.motor_id, cmd_ch.goal_value, cmd_ch.direction);
        cmds_accepted++;
        offer = 1'b0;
      end
      if (!offer && pending_cmds.size() != 0) begin
        if (gap_count < pending_cmds[0].gap) begin
          gap_count++;
        end else if (!pending_cmds[0].wait_idle || packet_bytes.size() == 0) begin
          cmd_ch.op         <= pending_cmds[0].op;
          cmd_ch.motor_id   <= pending_cmds[0].motor_id;
          cmd_ch.goal_value <= pending_cmds[0].goal;
          cmd_ch.direction  <= pending_cmds[0].direction;
          void'(pending_cmds.pop_front());
          gap_count = 0;
          offer     = 1'b1;
        end
      end
      cmd_ch.valid <= offer;
    end
  end

  // Byte monitor: check each transfer, then stall or hold off before the next
  always @(posedge clk_i or negedge rst_ni) begin : collect_bytes
    pkt_byte_t want;
    if (!rst_ni) begin
      tx_ch.ready <= 1'b0;
      stall_left = 0;
      hold_left  = 0;
    end else begin
      if (tx_ch.valid && tx_ch.ready) begin
        if (packet_bytes.size() == 0) begin
          error_count++;
          $display("%0t: unexpected byte: expected none, actual %02h last %0b",
                   $time, tx_ch.tx_byte, tx_ch.last);
        end else begin
          want = packet_bytes.pop_front();
          if (tx_ch.tx_byte !== want.tx_byte) flag_mismatch("tx_byte", want.tx_byte, tx_ch.tx_byte);
          if (tx_ch.last !== want.last) flag_mismatch("last", 8'(want.last), 8'(tx_ch.last));
        end
        bytes_seen++;
        if (tx_ch.last === 1'b1) begin
          packets_seen++;
          // Long hold-off once, so the command queue fills and stalls the input
          if (packets_seen == HoldAtPacket) hold_left = HoldCycles;
        end
        stall_left = (packets_seen >= BurstFrom && packets_seen < BurstTo) ? 0 :
                     $urandom_range(0, 6);
      end else if (hold_left != 0) begin
        hold_left--;
      end else if (stall_left != 0) begin
        stall_left--;
      end
      tx_ch.ready <= (hold_left == 0 && stall_left == 0);
    end
  end

  // Watchdog: give up after a long stretch with no transfer on either side
  always @(posedge clk_i) begin : watchdog
    if ((cmd_ch.valid && cmd_ch.ready) || (tx_ch.valid && tx_ch.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned r;
    op_e         op;
    logic [15:0] goal;
    int unsigned gap;
    cmd_ch.valid      = 1'b0;
    cmd_ch.op         = 2'd0;
    cmd_ch.motor_id   = 8'd0;
    cmd_ch.goal_value = 16'sd0;
    cmd_ch.direction  = 8'd0;
    tx_ch.ready       = 1'b0;
    rst_ni            = 1'b0;

    // Directed: field extremes, every kind, unused op, position with a direction set
    add_cmd(OP_VELOCITY, 8'h00, 16'h0000, 8'h00, 0, 1'b0);
    add_cmd(OP_POSITION, 8'hFF, 16'h7FFF, 8'hFF, 0, 1'b0);
    add_cmd(OP_TORQUE,   8'hFF, 16'h8000, 8'hFF, 0, 1'b0);
    add_cmd(OP_UNUSED,   8'hAA, 16'h5555, 8'h55, 0, 1'b0);
    add_cmd(OP_VELOCITY, 8'h01, 16'hFFFF, 8'h80, 1, 1'b0);
    add_cmd(OP_POSITION, 8'h7F, 16'h8000, 8'h00, 0, 1'b0);
    add_cmd(OP_TORQUE,   8'h80, 16'h7FFF, 8'h01, 2, 1'b0);
    add_cmd(OP_UNUSED,   8'hFF, 16'hFFFF, 8'hFF, 0, 1'b0);
    add_cmd(OP_VELOCITY, 8'h55, 16'h1234, 8'hAA, 0, 1'b0);
    add_cmd(OP_POSITION, 8'hFE, 16'h0001, 8'hFF, 3, 1'b0);
    add_cmd(OP_TORQUE,   8'h00, 16'h0000, 8'h00, 0, 1'b0);
    add_cmd(OP_VELOCITY, 8'hFF, 16'h7FFF, 8'hFF, 0, 1'b0);
    add_cmd(OP_POSITION, 8'h00, 16'hFFFF, 8'h00, 0, 1'b0);
    add_cmd(OP_TORQUE,   8'hAA, 16'hAA55, 8'h55, 6, 1'b1);
    add_cmd(OP_UNUSED,   8'h00, 16'h0000, 8'h00, 0, 1'b0);
    add_cmd(OP_VELOCITY, 8'hFD, 16'h8000, 8'h7F, 0, 1'b0);

    // Random: bursts without gaps, a queue-filling stretch and two idle waits
    for (int i = 0; i < RandomCmds; i++) begin
      r  = $urandom_range(0, 15);
      op = (r == 15) ? OP_UNUSED : op_e'(r % 3);
      case ($urandom_range(0, 7))
        0:       goal = 16'h8000;
        1:       goal = 16'h7FFF;
        2:       goal = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
        default: goal = 16'($urandom);
      endcase
      gap = ((i >= 40 && i < 60) || (i >= 90 && i < 140)) ? 0 : $urandom_range(0, 6);
      add_cmd(op, 8'($urandom), goal, 8'($urandom), gap, (i == 60 || i == 150));
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Drain: all commands taken, all bytes seen, then a short tail
    while (cmds_accepted != n_cmds) @(posedge clk_i);
    while (packet_bytes.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+design
design/scpf_pkg.sv
design/scpf_cmd_if.sv
design/scpf_byte_if.sv
design/scpf_front.sv
design/scpf_queue.sv
design/scpf_back.sv
design/servo_command_packet_framer.sv
design/scpf_checker.sv
sim/servo_command_packet_framer_test.sv
